// ----- design/mcws_pkg.sv -----
package mcws_pkg;

	localparam int unsigned OP_W        = 6;
	localparam int unsigned CW_W        = 31;
	localparam int unsigned STEP_W      = 5;
	localparam int unsigned LEN_W       = 5;
	localparam int unsigned NUM_OPS     = 42;
	localparam int unsigned MAX_MICRO   = 16;
	localparam int unsigned K_W         = 4;
	localparam int unsigned FETCH_STEPS = 3;
	localparam int unsigned NUM_CELLS   = FETCH_STEPS + MAX_MICRO;
	localparam int unsigned COND_STEP   = 8;

	localparam logic [OP_W-1:0] OP_JM  = OP_W'(14);
	localparam logic [OP_W-1:0] OP_JNZ = OP_W'(16);
	localparam logic [OP_W-1:0] OP_JZ  = OP_W'(17);

	// control line bit assignment
	localparam logic [CW_W-1:0] EN_PC  = CW_W'(1) << 0;
	localparam logic [CW_W-1:0] LD_MAR = CW_W'(1) << 1;
	localparam logic [CW_W-1:0] INC_PC = CW_W'(1) << 2;
	localparam logic [CW_W-1:0] EN_MDR = CW_W'(1) << 3;
	localparam logic [CW_W-1:0] LD_IR  = CW_W'(1) << 4;
	localparam logic [CW_W-1:0] EN_B   = CW_W'(1) << 5;
	localparam logic [CW_W-1:0] LD_TMP = CW_W'(1) << 6;
	localparam logic [CW_W-1:0] EN_ADD = CW_W'(1) << 7;
	localparam logic [CW_W-1:0] LD_A   = CW_W'(1) << 8;
	localparam logic [CW_W-1:0] EN_C   = CW_W'(1) << 9;
	localparam logic [CW_W-1:0] EN_AND = CW_W'(1) << 10;
	localparam logic [CW_W-1:0] LD_B   = CW_W'(1) << 11;
	localparam logic [CW_W-1:0] LD_C   = CW_W'(1) << 12;
	localparam logic [CW_W-1:0] UP_LD  = CW_W'(1) << 13;
	localparam logic [CW_W-1:0] LD_PCS = CW_W'(1) << 14;
	localparam logic [CW_W-1:0] EN_A   = CW_W'(1) << 15;
	localparam logic [CW_W-1:0] LD_MDR = CW_W'(1) << 16;
	localparam logic [CW_W-1:0] EN_TMP = CW_W'(1) << 17;
	localparam logic [CW_W-1:0] UP_EN  = CW_W'(1) << 18;
	localparam logic [CW_W-1:0] LD_PC  = CW_W'(1) << 19;
	localparam logic [CW_W-1:0] EN_CM  = CW_W'(1) << 20;
	localparam logic [CW_W-1:0] EN_DEC = CW_W'(1) << 21;
	localparam logic [CW_W-1:0] LD_IRP = CW_W'(1) << 22;
	localparam logic [CW_W-1:0] EN_IN  = CW_W'(1) << 23;
	localparam logic [CW_W-1:0] EN_INC = CW_W'(1) << 24;
	localparam logic [CW_W-1:0] EN_OR  = CW_W'(1) << 25;
	localparam logic [CW_W-1:0] LD_OUT = CW_W'(1) << 26;
	localparam logic [CW_W-1:0] EN_RL  = CW_W'(1) << 27;
	localparam logic [CW_W-1:0] EN_RR  = CW_W'(1) << 28;
	localparam logic [CW_W-1:0] EN_SUB = CW_W'(1) << 29;
	localparam logic [CW_W-1:0] EN_XOR = CW_W'(1) << 30;
	localparam logic [CW_W-1:0] PCM    = EN_PC | LD_MAR;
	localparam logic [CW_W-1:0] NONE   = '0;

	localparam logic [CW_W-1:0] FETCH_ROM [FETCH_STEPS] = '{PCM, INC_PC, EN_MDR | LD_IR};

	localparam logic [LEN_W-1:0] MICRO_LEN [NUM_OPS] = '{
		5'd2, 5'd2, 5'd2, 5'd2, 5'd4, 5'd16, 5'd1, 5'd2, 5'd2, 5'd2, 5'd4, 5'd1, 5'd6, 5'd6,
		5'd8, 5'd6, 5'd8, 5'd8, 5'd8, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd3, 5'd3, 5'd3,
		5'd1, 5'd2, 5'd2, 5'd4, 5'd4, 5'd1, 5'd1, 5'd7, 5'd8, 5'd2, 5'd2, 5'd2, 5'd2, 5'd4
	};

	// entry k is the control word of T-state k + FETCH_STEPS
	localparam logic [CW_W-1:0] MICRO_ROM [NUM_OPS][MAX_MICRO] = '{
		'{0: EN_B | LD_TMP, 1: EN_ADD | LD_A, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_ADD | LD_A, default: NONE},
		'{0: EN_B | LD_TMP, 1: EN_AND | LD_A, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_AND | LD_A, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: EN_AND | LD_A, default: NONE},
		'{PCM, INC_PC, EN_MDR | LD_B, PCM, INC_PC, EN_MDR | LD_C,
		  EN_PC | LD_TMP, UP_LD | LD_A, LD_PCS, PCM, INC_PC, EN_A | LD_MDR,
		  PCM, EN_TMP | LD_MDR, UP_EN | EN_B, EN_C | LD_PC},
		'{0: EN_CM | LD_A, default: NONE},
		'{0: EN_A | LD_TMP, 1: EN_DEC | LD_A, default: NONE},
		'{0: EN_B | LD_TMP, 1: EN_DEC | LD_B, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_DEC | LD_C, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_IRP, 3: EN_IN | LD_A, default: NONE},
		'{0: EN_INC | LD_A, default: NONE},
		'{0: EN_A | LD_TMP, 1: EN_B | LD_A, 2: EN_TMP | LD_B, 3: EN_INC | LD_TMP,
		  4: EN_B | LD_A, 5: EN_TMP | LD_B, default: NONE},
		'{0: EN_A | LD_TMP, 1: EN_C | LD_A, 2: EN_TMP | LD_C, 3: EN_INC | LD_TMP,
		  4: EN_C | LD_A, 5: EN_TMP | LD_C, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC, 5: NONE, 6: EN_MDR,
		  7: UP_EN | EN_TMP | LD_PC, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC | EN_MDR,
		  5: UP_EN | EN_TMP | LD_PC, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC, 5: NONE, 6: EN_MDR,
		  7: UP_EN | EN_TMP | LD_PC, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC, 5: NONE, 6: EN_MDR,
		  7: UP_EN | EN_TMP | LD_PC, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC, 5: EN_MDR,
		  6: UP_EN | EN_TMP | LD_MAR, 7: EN_MDR | LD_A, default: NONE},
		'{0: EN_B | LD_A, default: NONE},
		'{0: EN_C | LD_A, default: NONE},
		'{0: EN_A | LD_B, default: NONE},
		'{0: EN_C | LD_B, default: NONE},
		'{0: EN_A | LD_C, default: NONE},
		'{0: EN_B | LD_C, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_A, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_B, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_C, default: NONE},
		'{default: NONE},
		'{0: EN_B | LD_TMP, 1: EN_OR | LD_A, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_OR | LD_A, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: EN_OR | LD_A, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_IRP, 3: EN_A | LD_OUT, default: NONE},
		'{0: EN_RL | LD_A, default: NONE},
		'{0: EN_RR | LD_A, default: NONE},
		'{0: LD_PCS, 1: PCM, 2: INC_PC, 3: EN_MDR | LD_A, 4: PCM, 5: EN_MDR,
		  6: UP_EN | EN_A | LD_PC, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM, 4: INC_PC, 5: EN_MDR,
		  6: UP_EN | EN_TMP | LD_MAR, 7: EN_A | LD_MDR, default: NONE},
		'{0: EN_B | LD_TMP, 1: EN_SUB | LD_A, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_SUB | LD_A, default: NONE},
		'{0: EN_B | LD_TMP, 1: EN_XOR | LD_A, default: NONE},
		'{0: EN_C | LD_TMP, 1: EN_XOR | LD_A, default: NONE},
		'{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: EN_XOR | LD_A, default: NONE}
	};

	typedef struct packed {
		logic [CW_W-1:0]   cw;
		logic [STEP_W-1:0] step;
		logic              done;
		logic              bad;
	} result_t;

endpackage

// ----- design/mcws_cell.sv -----
module mcws_cell
	import mcws_pkg::*;
#(
	parameter int unsigned STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            restart,
	input  logic            token_in,
	input  logic [OP_W-1:0] opcode_index,
	input  logic            alu_zero,
	input  logic            alu_neg,
	output logic            token_out,
	output result_t         cell_out
);

	logic            token_q;
	logic [CW_W-1:0] word;
	logic            last;
	logic            miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= (STEP == 0);
		end else if (advance) begin
			token_q <= restart ? (STEP == 0) : token_in;
		end
	end

	generate
		if (STEP < FETCH_STEPS) begin : g_fetch
			assign word = FETCH_ROM[STEP];
			assign last = 1'b0;
			assign miss = 1'b0;
		end else begin : g_micro
			localparam int unsigned K = STEP - FETCH_STEPS;

			always_comb begin
				logic [LEN_W-1:0] len;
				len  = '0;
				word = '0;
				last = 1'b0;
				miss = 1'b1;
				if (opcode_index < OP_W'(NUM_OPS)) begin
					len = MICRO_LEN[opcode_index];
					if (LEN_W'(K) < len) begin
						miss = 1'b0;
						word = MICRO_ROM[opcode_index][K_W'(K)];
						last = (LEN_W'(K + 1) == len);
						// failed conditional jump test ends the instruction
						if (STEP == COND_STEP) begin
							if ((opcode_index == OP_JM && !alu_neg) ||
							    (opcode_index == OP_JNZ && alu_zero) ||
							    (opcode_index == OP_JZ && !alu_zero)) begin
								last = 1'b1;
							end
						end
					end
				end
			end
		end
	endgenerate

	assign token_out     = token_q;
	assign cell_out.cw   = token_q ? word : '0;
	assign cell_out.step = token_q ? STEP_W'(STEP) : '0;
	assign cell_out.done = token_q & last;
	assign cell_out.bad  = token_q & miss;

endmodule

// ----- design/mcws_out_buf.sv -----
module mcws_out_buf
	import mcws_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    wr_ready,
	output logic    rd_valid,
	input  logic    rd_en,
	output result_t rd_data
);

	result_t     ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push     = wr_en & wr_ready;
	assign pop      = rd_en & rd_valid;
	assign rd_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/microstep_control_word_sequencer_unit.sv -----
// Hardwired control sequencer: one input transaction is one machine tick (opcode
// and ALU flags), one output transaction is the control word for that tick, its
// T-state, instruction end on tlast and a missing-step flag on tuser. A new tick
// is taken every cycle unless the output queue is full; each result is registered
// in a two-entry output queue that lets input continue while one result waits.
// The T-state is a one-hot token moving along a row of 19 step cells, each
// decoding its own control word; the token returns to the first cell on
// instruction end or a missing step.
module microstep_control_word_sequencer_unit
	import mcws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // opcode_index[5:0], alu_zero[6], alu_neg[7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // control_word[30:0], step_number[35:31], zero pad
	output logic        m_tlast,
	output logic        m_tuser    // invalid_step
);

	logic            advance;
	logic            restart;
	logic            tok [NUM_CELLS];
	result_t         cell_res [NUM_CELLS];
	result_t         res;
	result_t         out_res;
	logic [OP_W-1:0] opcode_index;
	logic            alu_zero;
	logic            alu_neg;

	assign opcode_index = s_tdata[OP_W-1:0];
	assign alu_zero     = s_tdata[OP_W];
	assign alu_neg      = s_tdata[OP_W+1];
	assign advance      = s_tvalid & s_tready;

	genvar i;
	generate
		for (i = 0; i < NUM_CELLS; i++) begin : g_cell
			mcws_cell #(
				.STEP(i)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.advance     (advance),
				.restart     (restart),
				.token_in    ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i - 1]),
				.opcode_index(opcode_index),
				.alu_zero    (alu_zero),
				.alu_neg     (alu_neg),
				.token_out   (tok[i]),
				.cell_out    (cell_res[i])
			);
		end
	endgenerate

	always_comb begin
		res = '0;
		for (int n = 0; n < NUM_CELLS; n++) begin
			res = res | cell_res[n];
		end
	end

	assign restart = res.done | res.bad;

	mcws_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s_tvalid),
		.wr_data (res),
		.wr_ready(s_tready),
		.rd_valid(m_tvalid),
		.rd_en   (m_tready),
		.rd_data (out_res)
	);

	assign m_tdata = {4'b0, out_res.step, out_res.cw};
	assign m_tlast = out_res.done;
	assign m_tuser = out_res.bad;

endmodule

// ----- tb/microstep_control_word_sequencer_unit_test.sv -----
module microstep_control_word_sequencer_unit_test;
	import mcws_pkg::*;

	typedef enum logic [OP_W-1:0] {
		I_ADD_B, I_ADD_C, I_ANA_B, I_ANA_C, I_ANI, I_CALL, I_CMA, I_DCR_A, I_DCR_B,
		I_DCR_C, I_IN, I_INR_A, I_INR_B, I_INR_C, I_JM, I_JMP, I_JNZ, I_JZ, I_LDA,
		I_MOV_AB, I_MOV_AC, I_MOV_BA, I_MOV_BC, I_MOV_CA, I_MOV_CB, I_MVI_A, I_MVI_B,
		I_MVI_C, I_NOP, I_ORA_B, I_ORA_C, I_ORI, I_OUT, I_RAL, I_RAR, I_RET, I_STA,
		I_SUB_B, I_SUB_C, I_XRA_B, I_XRA_C, I_XRI
	} instr_e;

	localparam logic [OP_W-1:0] OP_TOP = '1;

	// microsteps after fetch, per instruction
	localparam int unsigned STEPS_OF [NUM_OPS] = '{
		2, 2, 2, 2, 4, 16, 1, 2, 2, 2, 4, 1, 6, 6, 8, 6, 8, 8, 8, 1, 1,
		1, 1, 1, 1, 3, 3, 3, 1, 2, 2, 4, 4, 1, 1, 7, 8, 2, 2, 2, 2, 4
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // opcode_index[5:0], alu_zero[6], alu_neg[7]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // control_word[30:0], step_number[35:31], zero pad
	logic        m_tlast;   // instruction_done
	logic        m_tuser;   // invalid_step

	logic [STEP_W-1:0] tick_ctr = '0;
	result_t           word_q [$];
	int                src_idle = 0;
	int                dst_idle = 0;
	int                mismatches = 0;
	int                ticks_sent = 0;

	microstep_control_word_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("microstep_control_word_sequencer_unit_test: FAIL");
		$finish;
	end

	function automatic result_t predict_tick(input logic [OP_W-1:0] op, input logic zf,
			input logic sf);
		result_t           r;
		logic [CW_W-1:0]   row [MAX_MICRO];
		int unsigned       k;
		r.cw   = '0;
		r.step = tick_ctr;
		r.done = 1'b0;
		r.bad  = 1'b0;
		if (tick_ctr < FETCH_STEPS) begin
			case (tick_ctr)
				0: r.cw = EN_PC | LD_MAR;
				1: r.cw = INC_PC;
				default: r.cw = EN_MDR | LD_IR;
			endcase
		end else begin
			k = tick_ctr - FETCH_STEPS;
			if (op >= NUM_OPS || k >= STEPS_OF[op]) begin
				r.bad = 1'b1;
			end else begin
				for (int i = 0; i < MAX_MICRO; i++)
					row[i] = '0;
				case (op)
					I_ADD_B: row = '{0: EN_B | LD_TMP, 1: EN_ADD | LD_A, default: '0};
					I_ADD_C: row = '{0: EN_C | LD_TMP, 1: EN_ADD | LD_A, default: '0};
					I_ANA_B: row = '{0: EN_B | LD_TMP, 1: EN_AND | LD_A, default: '0};
					I_ANA_C: row = '{0: EN_C | LD_TMP, 1: EN_AND | LD_A, default: '0};
					I_ANI: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP,
						3: EN_AND | LD_A, default: '0};
					I_CALL: row = '{PCM, INC_PC, EN_MDR | LD_B, PCM, INC_PC, EN_MDR | LD_C,
						EN_PC | LD_TMP, UP_LD | LD_A, LD_PCS, PCM, INC_PC, EN_A | LD_MDR,
						PCM, EN_TMP | LD_MDR, UP_EN | EN_B, EN_C | LD_PC};
					I_CMA: row[0] = EN_CM | LD_A;
					I_DCR_A: row = '{0: EN_A | LD_TMP, 1: EN_DEC | LD_A, default: '0};
					I_DCR_B: row = '{0: EN_B | LD_TMP, 1: EN_DEC | LD_B, default: '0};
					I_DCR_C: row = '{0: EN_C | LD_TMP, 1: EN_DEC | LD_C, default: '0};
					I_IN: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_IRP,
						3: EN_IN | LD_A, default: '0};
					I_INR_A: row[0] = EN_INC | LD_A;
					I_INR_B: row = '{0: EN_A | LD_TMP, 1: EN_B | LD_A, 2: EN_TMP | LD_B,
						3: EN_INC | LD_TMP, 4: EN_B | LD_A, 5: EN_TMP | LD_B,
						default: '0};
					I_INR_C: row = '{0: EN_A | LD_TMP, 1: EN_C | LD_A, 2: EN_TMP | LD_C,
						3: EN_INC | LD_TMP, 4: EN_C | LD_A, 5: EN_TMP | LD_C,
						default: '0};
					I_JM, I_JNZ, I_JZ: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP,
						3: PCM, 4: INC_PC, 5: '0, 6: EN_MDR,
						7: UP_EN | EN_TMP | LD_PC, default: '0};
					I_JMP: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM,
						4: INC_PC | EN_MDR, 5: UP_EN | EN_TMP | LD_PC, default: '0};
					I_LDA: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM,
						4: INC_PC, 5: EN_MDR, 6: UP_EN | EN_TMP | LD_MAR,
						7: EN_MDR | LD_A, default: '0};
					I_MOV_AB: row[0] = EN_B | LD_A;
					I_MOV_AC: row[0] = EN_C | LD_A;
					I_MOV_BA: row[0] = EN_A | LD_B;
					I_MOV_BC: row[0] = EN_C | LD_B;
					I_MOV_CA: row[0] = EN_A | LD_C;
					I_MOV_CB: row[0] = EN_B | LD_C;
					I_MVI_A: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_A, default: '0};
					I_MVI_B: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_B, default: '0};
					I_MVI_C: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_C, default: '0};
					I_ORA_B: row = '{0: EN_B | LD_TMP, 1: EN_OR | LD_A, default: '0};
					I_ORA_C: row = '{0: EN_C | LD_TMP, 1: EN_OR | LD_A, default: '0};
					I_ORI: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP,
						3: EN_OR | LD_A, default: '0};
					I_OUT: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_IRP,
						3: EN_A | LD_OUT, default: '0};
					I_RAL: row[0] = EN_RL | LD_A;
					I_RAR: row[0] = EN_RR | LD_A;
					I_RET: row = '{0: LD_PCS, 1: PCM, 2: INC_PC, 3: EN_MDR | LD_A,
						4: PCM, 5: EN_MDR, 6: UP_EN | EN_A | LD_PC, default: '0};
					I_STA: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP, 3: PCM,
						4: INC_PC, 5: EN_MDR, 6: UP_EN | EN_TMP | LD_MAR,
						7: EN_A | LD_MDR, default: '0};
					I_SUB_B: row = '{0: EN_B | LD_TMP, 1: EN_SUB | LD_A, default: '0};
					I_SUB_C: row = '{0: EN_C | LD_TMP, 1: EN_SUB | LD_A, default: '0};
					I_XRA_B: row = '{0: EN_B | LD_TMP, 1: EN_XOR | LD_A, default: '0};
					I_XRA_C: row = '{0: EN_C | LD_TMP, 1: EN_XOR | LD_A, default: '0};
					I_XRI: row = '{0: PCM, 1: INC_PC, 2: EN_MDR | LD_TMP,
						3: EN_XOR | LD_A, default: '0};
					default: ;
				endcase
				r.cw   = row[k];
				r.done = (k + 1 == STEPS_OF[op]);
				// failed branch test ends the instruction
				if (tick_ctr == COND_STEP) begin
					if (op == I_JM && !sf)
						r.done = 1'b1;
					if (op == I_JNZ && zf)
						r.done = 1'b1;
					if (op == I_JZ && !zf)
						r.done = 1'b1;
				end
			end
		end
		tick_ctr = (r.done || r.bad) ? '0 : tick_ctr + 1'b1;
		return r;
	endfunction

	task automatic send_tick(input logic [OP_W-1:0] op, input logic zf, input logic sf);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {sf, zf, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		word_q.push_back(predict_tick(op, zf, sf));
		ticks_sent++;
	endtask

	task automatic send_instruction(input logic [OP_W-1:0] op, input logic zf, input logic sf);
		do
			send_tick(op, zf, sf);
		while (tick_ctr != 0);
	endtask

	task automatic test_fetch_and_bad_opcode();
		// opcode ignored during fetch, then no table entry
		send_tick(OP_TOP, 1'b1, 1'b1);
		send_tick(OP_TOP, 1'b1, 1'b1);
		send_tick(OP_TOP, 1'b1, 1'b1);
		send_tick(OP_TOP, 1'b0, 1'b0);
	endtask

	task automatic test_conditional_jumps();
		send_instruction(I_JZ, 1'b0, 1'b0);
		send_instruction(I_JM, 1'b0, 1'b1);
	endtask

	task automatic test_random_stream(input int sidle, input int didle, input int n_items);
		int first;
		src_idle = sidle;
		dst_idle = didle;
		first = ticks_sent;
		while (ticks_sent - first < n_items) begin
			if ($urandom_range(99) < 85)
				send_instruction(OP_W'($urandom_range(NUM_OPS - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				send_tick(OP_W'($urandom_range(OP_TOP)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= dst_idle);

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.cw   = m_tdata[30:0];
			got.step = m_tdata[35:31];
			got.done = m_tlast;
			got.bad  = m_tuser;
			if (word_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: cw=%h step=%0d done=%b bad=%b",
						got.cw, got.step, got.done, got.bad);
			end else begin
				want = word_q.pop_front();
				if (got.cw !== want.cw || got.step !== want.step ||
						got.done !== want.done || got.bad !== want.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp cw=%h step=%0d done=%b bad=%b,",
							want.cw, want.step, want.done, want.bad,
							" got cw=%h step=%0d done=%b bad=%b",
							got.cw, got.step, got.done, got.bad);
				end
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (10) @(posedge clk);
		arst_n   <= 1'b1;
		src_idle = 36;
		dst_idle = 70;
		test_fetch_and_bad_opcode();
		test_conditional_jumps();
		test_random_stream(36, 70, 580);
		test_random_stream(70, 36, 580);
		test_random_stream(0, 0, 570);
		s_tvalid <= 1'b0;
		while (word_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && word_q.size() == 0)
			$display("microstep_control_word_sequencer_unit_test: PASS");
		else
			$display("microstep_control_word_sequencer_unit_test: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
design/mcws_pkg.sv
design/mcws_cell.sv
design/mcws_out_buf.sv
design/microstep_control_word_sequencer_unit.sv
tb/microstep_control_word_sequencer_unit_test.sv
